@@ sv/stun_rt_pkg.sv @@
// Shared types and constants for the transaction retry table.
// No dependencies; imported by the controller, the datapath and the top level.
package stun_rt_pkg;

    localparam int IN_W  = 136;
    localparam int OUT_W = 144;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 16;
    localparam int CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP      = 2'd2;

    localparam logic [15:0]      INTERVAL_RST = 16'd1000;
    localparam logic [7:0]       LIMIT_RST    = 8'd3;
    localparam logic [CNT_W-1:0] CAP_RST      = 4'd3;
    localparam logic [CNT_W-1:0] MAX_SENDS    = 4'd15;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;
    localparam logic RES_SEND    = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    typedef struct packed {
        logic ready;
        logic load;
        logic tick;
        logic rd;
        logic step_idx;
        logic commit;
        logic summary;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic kind;
        logic walk;
        logic skip;
        logic last_idx;
        logic match;
        logic send;
        logic stop;
        logic out_free;
    } sts_t;

endpackage

@@ sv/stun_transaction_retry_table_core.sv @@
// Top level of the binding-request retry table: controller plus datapath.
// Depends on stun_rt_pkg, stun_rt_ctrl and stun_rt_dp.
//
// One input word at a time. A load word writes its slot and then issues its summary.
// An event word with a timer or response walks the table in slot order through one
// shared memory read port, skipping inactive or finished slots and reading each live
// slot; the outstanding cap ends the walk early when no response is pending. Send
// results and the summary leave through a single output register; a stalled output
// holds the walk. The table needs no clearing pass.
module stun_transaction_retry_table_core
    import stun_rt_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot[5:0], id_magic[37:6], id_first[69:38], id_second[101:70], now_ms[133:102],
    // got_response[134], timer_tick[135]
    input  logic [IN_W-1:0]      s_tdata,
    // kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // send_slot[5:0], send_magic[37:6], send_first[69:38], send_second[101:70],
    // send_third[133:102], outstanding[137:134], matched[138], zero[143:139]
    output logic [OUT_W-1:0]     m_tdata,
    // result_kind
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    stun_rt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    stun_rt_dp #(
        .SLOTS (SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_tready = cmd.ready;

`ifndef SYNTHESIS
    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == RES_SUMMARY) |-> (m_tlast && m_tdata[133:0] == '0))
        else $error("summary word carries send fields");

    a_send_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == RES_SEND) |-> (!m_tlast && !m_tdata[138]))
        else $error("send word marked last or matched");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && sts.send && !sts.match) |-> sts.out_free)
        else $error("send result overwrites a pending word");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new word taken while one is in progress");
`endif

endmodule

@@ sv/stun_rt_ctrl.sv @@
// Controller state machine: sequences load, table walk and summary per word.
// Depends on stun_rt_pkg (cmd_t, sts_t).
module stun_rt_ctrl
    import stun_rt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_EVAL,
        ST_SUMMARY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (sts.kind == KIND_LOAD)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    cmd.tick = 1'b1;
                    state_next = sts.walk ? ST_SCAN : ST_SUMMARY;
                end
            end
            ST_SCAN:
            begin
                if (sts.skip)
                begin
                    if (sts.last_idx)
                        state_next = ST_SUMMARY;
                    else
                        cmd.step_idx = 1'b1;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.match || !sts.send || sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    if ((!sts.match && sts.stop) || sts.last_idx)
                        state_next = ST_SUMMARY;
                    else
                    begin
                        cmd.step_idx = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SUMMARY:
            begin
                if (sts.out_free)
                begin
                    cmd.summary = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/stun_rt_dp.sv @@
// Datapath: config registers, slot table memories, match/due logic, output register.
// Depends on stun_rt_pkg; driven by stun_rt_ctrl commands.
module stun_rt_dp
    import stun_rt_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 s_tvalid,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // config
    logic [15:0]      interval_reg;
    logic [7:0]       limit_reg;
    logic [CNT_W-1:0] cap_reg;

    // captured word
    logic        kind_reg;
    logic [5:0]  slot_reg;
    logic [95:0] ids_reg;
    logic [31:0] now_reg;
    logic        rcv_reg;
    logic        tick_reg;

    // walk state
    logic [IW-1:0]    idx_reg;
    logic [CNT_W-1:0] n_reg;
    logic             matched_reg;
    logic [CNT_W-1:0] out_reg;
    logic [CNT_W-1:0] out_next;
    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] finished_reg;

    // table memories
    logic [95:0] ids_mem [SLOTS];
    logic [31:0] ls_mem  [SLOTS];
    logic [7:0]  rt_mem  [SLOTS];
    logic [95:0] rd_ids_reg;
    logic [31:0] rd_ls_reg;
    logic [7:0]  rd_rt_reg;

    // output register
    logic             m_valid_reg;
    logic             m_kind_reg;
    logic [5:0]       m_slot_reg;
    logic [95:0]      m_ids_reg;
    logic [31:0]      m_third_reg;
    logic [CNT_W-1:0] m_out_reg;
    logic             m_matched_reg;
    logic             m_last_reg;

    logic             accept;
    logic [8:0]       slot_ext;
    logic [IW-1:0]    lidx;
    logic             load_ok;
    logic             due;
    logic             match_w;
    logic             send_w;
    logic [CNT_W-1:0] out_after;
    logic             out_free;
    logic             do_send;
    logic [8:0]       idx_ext;

    assign accept   = cmd.ready & s_tvalid;
    assign slot_ext = 9'(slot_reg);
    assign lidx     = slot_ext[IW-1:0];
    assign load_ok  = slot_ext < 9'(SLOTS);
    assign idx_ext  = 9'(idx_reg);

    assign due     = ({1'b0, rd_ls_reg} + 33'(interval_reg)) < {1'b0, now_reg};
    assign match_w = rcv_reg && (rd_ids_reg == ids_reg);
    assign send_w  = (n_reg < MAX_SENDS) && (out_reg < cap_reg) && due
                   && (rd_rt_reg < limit_reg);
    assign out_after = send_w ? out_reg + 4'd1 : out_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign do_send   = cmd.commit && !match_w && send_w;

    always_comb
    begin
        sts.in_valid = s_tvalid;
        sts.kind     = kind_reg;
        sts.walk     = tick_reg || rcv_reg;
        sts.skip     = !active_reg[idx_reg] || finished_reg[idx_reg];
        sts.last_idx = idx_reg == IW'(SLOTS - 1);
        sts.match    = match_w;
        sts.send     = send_w;
        sts.stop     = (out_after >= cap_reg) && !rcv_reg;
        sts.out_free = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            limit_reg    <= LIMIT_RST;
            cap_reg      <= CAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_LIMIT:    limit_reg    <= cfg_data[7:0];
                REG_CAP:      cap_reg      <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            slot_reg <= s_tdata[5:0];
            ids_reg  <= s_tdata[101:6];
            now_reg  <= s_tdata[133:102];
            tick_reg <= s_tdata[135];
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.tick && tick_reg && out_reg != '0)
            out_next = out_reg - 4'd1;
        else if (cmd.commit && match_w)
        begin
            if (out_reg != '0)
                out_next = out_reg - 4'd1;
        end
        else if (do_send)
            out_next = out_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_reg      <= 1'b0;
            idx_reg      <= '0;
            n_reg        <= '0;
            matched_reg  <= 1'b0;
            out_reg      <= '0;
            active_reg   <= '0;
            finished_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
            if (accept)
            begin
                rcv_reg     <= s_tdata[134];
                idx_reg     <= '0;
                n_reg       <= '0;
                matched_reg <= 1'b0;
            end
            if (cmd.load && load_ok)
            begin
                active_reg[lidx]   <= 1'b1;
                finished_reg[lidx] <= 1'b0;
            end
            if (cmd.step_idx)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.commit && match_w)
            begin
                finished_reg[idx_reg] <= 1'b1;
                rcv_reg     <= 1'b0;
                matched_reg <= 1'b1;
            end
            if (do_send)
                n_reg <= n_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
            ids_mem[lidx] <= ids_reg;
        if (cmd.rd)
            rd_ids_reg <= ids_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            ls_mem[lidx] <= '0;
            rt_mem[lidx] <= '0;
        end
        else if (do_send)
        begin
            ls_mem[idx_reg] <= now_reg;
            rt_mem[idx_reg] <= rd_rt_reg + 8'd1;
        end
        if (cmd.rd)
        begin
            rd_ls_reg <= ls_mem[idx_reg];
            rd_rt_reg <= rt_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (do_send || cmd.summary)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (do_send)
        begin
            m_kind_reg    <= RES_SEND;
            m_slot_reg    <= idx_ext[5:0];
            m_ids_reg     <= rd_ids_reg;
            m_third_reg   <= {now_reg[31:8], rd_rt_reg};
            m_out_reg     <= out_next;
            m_matched_reg <= 1'b0;
            m_last_reg    <= 1'b0;
        end
        else if (cmd.summary)
        begin
            m_kind_reg    <= RES_SUMMARY;
            m_slot_reg    <= '0;
            m_ids_reg     <= '0;
            m_third_reg   <= '0;
            m_out_reg     <= out_reg;
            m_matched_reg <= matched_reg;
            m_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_matched_reg, m_out_reg, m_third_reg, m_ids_reg, m_slot_reg};

endmodule
